### rtl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

### rtl/sha256_hash.sv
`timescale 1ns / 1ps
// SHA-256 hasher, one message byte per input transfer.
// Input channel: s_data_byte, s_byte_valid, s_end_of_message with s_valid/s_ready.
// Each byte is written into the window. The 64th byte of a block starts a compression:
// 64 rounds through one shared round unit, one round per cycle, then a fold of
// the working words into the chaining words; s_ready is low meanwhile.
// An end transfer pads in place, one padding byte at a time, compresses one or
// two blocks, then emits eight digest words on m_* (m_digest_word, m_word_index,
// m_last_word with m_valid/m_ready), H0 first. A stall on m_ready holds the word.
// After the last word the chaining words reload the initial values and the
// block accepts a new message. While it pads, compresses or emits, s_ready
// is low and no byte is taken.
// Reset (aresetn low, synchronous) clears the fill count and length, reloads
// the chaining words with the initial values and drops any pending output.
module sha256_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sha_pkg::state_t state_reg, state_next;

    logic [31:0] wmem [16];          // message schedule window, word-wise
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;
    logic        fin_reg;            // compressing a final block
    logic        len_done_reg;       // length field written
    logic        mark_reg;           // pad marker written
    logic        room_reg;           // length field goes into the current block
    logic [2:0]  idx_reg;

    // byte write port into the window
    logic        bw_en;
    logic [5:0]  bw_addr;
    logic [7:0]  bw_data;

    logic [31:0] w_cur, sg0, sg1, w_new, t1, t2;
    logic [31:0] e, a;

    assign s_ready = (state_reg == sha_pkg::ST_IDLE);
    assign m_valid = (state_reg == sha_pkg::ST_EMIT);
    assign m_digest_word = h_reg[idx_reg];
    assign m_word_index = idx_reg;
    assign m_last_word = (idx_reg == 3'd7);

    // schedule: window slot rnd[3:0] holds w[i] for i<16, else build it
    always_comb begin
        sg0 = sha_pkg::rotr(wmem[rnd_reg[3:0] + 4'd1], 7)
            ^ sha_pkg::rotr(wmem[rnd_reg[3:0] + 4'd1], 18)
            ^ (wmem[rnd_reg[3:0] + 4'd1] >> 3);
        sg1 = sha_pkg::rotr(wmem[rnd_reg[3:0] + 4'd14], 17)
            ^ sha_pkg::rotr(wmem[rnd_reg[3:0] + 4'd14], 19)
            ^ (wmem[rnd_reg[3:0] + 4'd14] >> 10);
        w_new = wmem[rnd_reg[3:0]] + sg0 + wmem[rnd_reg[3:0] + 4'd9] + sg1;
        w_cur = (rnd_reg < 6'd16) ? wmem[rnd_reg[3:0]] : w_new;
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::ROUND_K[rnd_reg] + w_cur;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb begin
        state_next = state_reg;
        bw_en = 1'b0;
        bw_addr = fill_reg;
        bw_data = s_data_byte;
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                if (s_valid) begin
                    bw_en = s_byte_valid;
                    if (s_byte_valid && fill_reg == 6'd63) begin
                        state_next = sha_pkg::ST_ROUND;
                    end else if (s_end_of_message) begin
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                bw_en = 1'b1;
                // first pad byte is the marker
                priority if (!mark_reg) begin
                    bw_data = sha_pkg::PAD_MARK;
                end else if (room_reg && fill_reg >= 6'd56) begin
                    bw_data = len_reg[8 * (7 - fill_reg[2:0]) +: 8];
                end else begin
                    bw_data = 8'd0;
                end
                if (fill_reg == 6'd63) begin
                    state_next = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND: begin
                if (rnd_reg == 6'd63) begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end
            sha_pkg::ST_FOLD: begin
                priority if (fin_reg && len_done_reg) begin
                    state_next = sha_pkg::ST_EMIT;
                end else if (fin_reg) begin
                    state_next = sha_pkg::ST_PAD;
                end else begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_EMIT: begin
                if (m_ready && idx_reg == 3'd7) begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // window memory: byte writes while filling, word writes while scheduling
    always_ff @(posedge aclk) begin
        if (bw_en) begin
            wmem[bw_addr[5:2]][8 * (3 - bw_addr[1:0]) +: 8] <= bw_data;
        end else if (state_reg == sha_pkg::ST_ROUND && rnd_reg >= 6'd16) begin
            wmem[rnd_reg[3:0]] <= w_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
            fin_reg <= 1'b0;
            len_done_reg <= 1'b0;
            mark_reg <= 1'b0;
            room_reg <= 1'b0;
            idx_reg <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::INIT_HASH[i];
        end else begin
            if (bw_en) fill_reg <= fill_reg + 6'd1;
            unique case (state_reg)
                sha_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        if (s_byte_valid) len_reg <= len_reg + 64'd8;
                        fin_reg <= s_end_of_message;
                        len_done_reg <= 1'b0;
                        mark_reg <= 1'b0;
                        room_reg <= 1'b0;
                        if (s_byte_valid && fill_reg == 6'd63) begin
                            rnd_reg <= '0;
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        end
                    end
                end
                sha_pkg::ST_PAD: begin
                    // a marker in the last eight bytes pushes the length to an extra block
                    if (!mark_reg) begin
                        mark_reg <= 1'b1;
                        room_reg <= (fill_reg < 6'd56);
                    end
                    if (fill_reg == 6'd63) begin
                        rnd_reg <= '0;
                        for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        len_done_reg <= mark_reg && room_reg;
                    end
                end
                sha_pkg::ST_ROUND: begin
                    rnd_reg <= rnd_reg + 6'd1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                sha_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    idx_reg <= '0;
                    if (fin_reg) room_reg <= 1'b1;
                end
                sha_pkg::ST_EMIT: begin
                    if (m_ready) begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7) begin
                            fill_reg <= '0;
                            len_reg <= '0;
                            fin_reg <= 1'b0;
                            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::INIT_HASH[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### rtl/sha_checker.sv
`timescale 1ns / 1ps
module sha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_word_index,
    input logic        m_last_word
);
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input open while digest pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_last_word == (m_word_index == 3'd7)) else $error("last flag mismatch");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=> m_valid && m_word_index == $past(m_word_index) + 3'd1)
        else $error("digest word skipped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_index)) else $error("stalled word moved");
endmodule

bind sha256_hash sha_checker u_sha_checker (.*);
